[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbs: same-cycle check failed");

// Next-cycle implication.
`define LBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbs: next-cycle check failed");

`endif

[rtl/lbs_pkg.sv]
`default_nettype none

package lbs_pkg;

    localparam int NUM_BUTTONS = 12;
    localparam int BTN_W      = NUM_BUTTONS;
    localparam int IDX_W      = 4;
    localparam int KIND_W     = 3;
    localparam int TICK_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_NORMAL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPECIAL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SYSRQ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POWER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REBOOT  = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LOW   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_MASK  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPECIAL_MASK = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SYSRQ_MASK   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COMBO_IDX    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COMBO_EN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_POWER_TICKS  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_REBOOT_TICKS = 3'd7;

    localparam logic [BTN_W-1:0]  RST_ACTIVE_LOW   = 12'd4095;
    localparam logic [BTN_W-1:0]  RST_NORMAL_MASK  = 12'd4095;
    localparam logic [BTN_W-1:0]  RST_SPECIAL_MASK = 12'd2319;
    localparam logic [BTN_W-1:0]  RST_SYSRQ_MASK   = 12'd2063;
    localparam logic [IDX_W-1:0]  RST_COMBO_IDX    = 4'd10;
    localparam logic              RST_COMBO_EN     = 1'b1;
    localparam logic [TICK_W-1:0] RST_POWER_TICKS  = 16'd100;
    localparam logic [TICK_W-1:0] RST_REBOOT_TICKS = 16'd250;

    typedef struct packed {
        logic [BTN_W-1:0]  active_low_mask;
        logic [BTN_W-1:0]  normal_code_mask;
        logic [BTN_W-1:0]  special_code_mask;
        logic [BTN_W-1:0]  sysrq_code_mask;
        logic [IDX_W-1:0]  combo_idx;
        logic              combo_en;
        logic [TICK_W-1:0] power_ticks;
        logic [TICK_W-1:0] reboot_ticks;
    } t_cfg;

    // One tick's work, handed from the layer logic to the serializer.
    typedef struct packed {
        logic [BTN_W-1:0]  sel;
        logic [BTN_W-1:0]  lvl;
        logic [KIND_W-1:0] key_kind;
        logic              cnt_pend;
        logic [KIND_W-1:0] cnt_kind;
    } t_job;

endpackage

`default_nettype wire

[rtl/lbs_in_if.sv]
`default_nettype none

interface lbs_in_if;
    logic                     valid;
    logic                     ready;
    logic [lbs_pkg::BTN_W-1:0] buttons_raw;
    logic                     slider_held;

    modport source (output valid, output buttons_raw, output slider_held, input ready);
    modport sink   (input valid, input buttons_raw, input slider_held, output ready);
endinterface

`default_nettype wire

[rtl/lbs_out_if.sv]
`default_nettype none

interface lbs_out_if;
    logic                      valid;
    logic                      ready;
    logic [lbs_pkg::KIND_W-1:0] event_kind;
    logic [lbs_pkg::IDX_W-1:0]  button_index;
    logic                      pressed;
    logic                      last;

    modport source (output valid, output event_kind, output button_index, output pressed,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input button_index, input pressed,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/layered_button_scanner_long_press_unit.sv]
// Layered button scanner with power-slider long press.
// i_btn: one beat per scan tick, raw button levels plus slider level.
// o_evt: zero to thirteen event beats per tick (key events lowest button
//   first, then at most one power click or reboot); last marks the final
//   beat of a tick. A tick with no events produces no beat.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle;
//   write only while no tick is in flight.
// A tick is taken, then the serializer shifts through the selected button
//   mask one button per cycle while o_evt is not stalled, stops once no set
//   bit is left and closes with a step that carries the hold-counter event
//   if any.
// i_btn.ready is high whenever the serializer is idle, even while the
//   final event of the previous tick still sits in the output register.
// A stalled o_evt freezes the serializer; no beat is dropped.
// Reset (synchronous, active low) loads the register defaults, clears all
//   layer state and the hold counter, and empties the output register.
`default_nettype none

module layered_button_scanner_long_press_unit #(
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lbs_pkg::CFG_ADDR_W-1:0] i_cfg_idx,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lbs_in_if.sink                              i_btn,
    lbs_out_if.source                           o_evt
);

    lbs_pkg::t_cfg cfg;
    lbs_pkg::t_job job;
    logic          busy;
    logic          load;

    assign i_btn.ready = !busy;
    assign load        = i_btn.valid && !busy;

    lbs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lbs_layer #(
        .COUNT_BITS  (COUNT_BITS)
    ) u_layer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_load   (load),
        .i_raw    (i_btn.buttons_raw),
        .i_slider (i_btn.slider_held),
        .o_job    (job)
    );

    lbs_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_out_ready (o_evt.ready),
        .o_busy      (busy),
        .o_valid     (o_evt.valid),
        .o_kind      (o_evt.event_kind),
        .o_idx       (o_evt.button_index),
        .o_pressed   (o_evt.pressed),
        .o_last      (o_evt.last)
    );

endmodule

`default_nettype wire

[rtl/lbs_cfg_regs.sv]
`default_nettype none

module lbs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lbs_pkg::CFG_ADDR_W-1:0]   i_cfg_idx,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lbs_pkg::t_cfg                         o_cfg
);

    lbs_pkg::t_cfg r_cfg;
    lbs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lbs_pkg::REG_ACTIVE_LOW:
                    n_cfg.active_low_mask = i_cfg_data[lbs_pkg::BTN_W-1:0];
                lbs_pkg::REG_NORMAL_MASK:
                    n_cfg.normal_code_mask = i_cfg_data[lbs_pkg::BTN_W-1:0];
                lbs_pkg::REG_SPECIAL_MASK:
                    n_cfg.special_code_mask = i_cfg_data[lbs_pkg::BTN_W-1:0];
                lbs_pkg::REG_SYSRQ_MASK:
                    n_cfg.sysrq_code_mask = i_cfg_data[lbs_pkg::BTN_W-1:0];
                lbs_pkg::REG_COMBO_IDX:
                    n_cfg.combo_idx = i_cfg_data[lbs_pkg::IDX_W-1:0];
                lbs_pkg::REG_COMBO_EN:
                    n_cfg.combo_en = i_cfg_data[0];
                lbs_pkg::REG_POWER_TICKS:
                    n_cfg.power_ticks = i_cfg_data[lbs_pkg::TICK_W-1:0];
                lbs_pkg::REG_REBOOT_TICKS:
                    n_cfg.reboot_ticks = i_cfg_data[lbs_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low_mask   <= lbs_pkg::RST_ACTIVE_LOW;
            r_cfg.normal_code_mask  <= lbs_pkg::RST_NORMAL_MASK;
            r_cfg.special_code_mask <= lbs_pkg::RST_SPECIAL_MASK;
            r_cfg.sysrq_code_mask   <= lbs_pkg::RST_SYSRQ_MASK;
            r_cfg.combo_idx         <= lbs_pkg::RST_COMBO_IDX;
            r_cfg.combo_en          <= lbs_pkg::RST_COMBO_EN;
            r_cfg.power_ticks       <= lbs_pkg::RST_POWER_TICKS;
            r_cfg.reboot_ticks      <= lbs_pkg::RST_REBOOT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/lbs_layer.sv]
`default_nettype none

module lbs_layer #(
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lbs_pkg::t_cfg               i_cfg,
    input  wire logic                        i_load,
    input  wire logic [lbs_pkg::BTN_W-1:0]   i_raw,
    input  wire logic                        i_slider,
    output lbs_pkg::t_job                    o_job
);

    localparam int NB_EFF = (lbs_pkg::NUM_BUTTONS < lbs_pkg::BTN_W) ?
                            lbs_pkg::NUM_BUTTONS : lbs_pkg::BTN_W;
    localparam logic [lbs_pkg::BTN_W-1:0] BTN_MASK =
        lbs_pkg::BTN_W'((64'd1 << NB_EFF) - 64'd1);
    localparam logic [lbs_pkg::IDX_W-1:0] NB_IDX = lbs_pkg::IDX_W'(NB_EFF);
    localparam int CMP_W = (COUNT_BITS > lbs_pkg::TICK_W) ? COUNT_BITS : lbs_pkg::TICK_W;

    logic [lbs_pkg::BTN_W-1:0] r_normal, n_normal;
    logic [lbs_pkg::BTN_W-1:0] r_special, n_special;
    logic [lbs_pkg::BTN_W-1:0] r_sysrq, n_sysrq;
    logic                      r_slider, n_slider;
    logic [COUNT_BITS-1:0]     r_hold, n_hold;

    logic [lbs_pkg::BTN_W-1:0] s;
    logic                      combo;
    logic                      hit_power;
    logic                      hit_reboot;

    assign s     = (i_raw ^ i_cfg.active_low_mask) & BTN_MASK;
    assign combo = i_cfg.combo_en && (i_cfg.combo_idx < NB_IDX) && s[i_cfg.combo_idx];
    assign hit_power  = CMP_W'(r_hold) == CMP_W'(i_cfg.power_ticks);
    assign hit_reboot = CMP_W'(r_hold) == CMP_W'(i_cfg.reboot_ticks);

    always_comb begin
        n_normal  = r_normal;
        n_special = r_special;
        n_sysrq   = r_sysrq;
        n_slider  = r_slider;
        n_hold    = r_hold;
        o_job.sel      = '0;
        o_job.lvl      = s;
        o_job.key_kind = lbs_pkg::KIND_NORMAL;
        o_job.cnt_pend = 1'b0;
        o_job.cnt_kind = lbs_pkg::KIND_POWER;
        if (!i_slider) begin
            o_job.sel = (s ^ r_normal) & i_cfg.normal_code_mask;
            n_hold    = '0;
            n_normal  = s;
            n_slider  = 1'b0;
        end else if (combo) begin
            o_job.sel      = (s ^ r_sysrq) & s & i_cfg.sysrq_code_mask;
            o_job.key_kind = lbs_pkg::KIND_SYSRQ;
            n_hold         = '0;
            n_sysrq        = s;
        end else begin
            o_job.sel      = (s ^ r_special) & i_cfg.special_code_mask;
            o_job.key_kind = lbs_pkg::KIND_SPECIAL;
            if (!r_slider) begin
                n_hold = COUNT_BITS'(1);
            end else if ((|r_hold) && !(&r_hold)) begin
                o_job.cnt_pend = hit_power | hit_reboot;
                o_job.cnt_kind = hit_reboot ? lbs_pkg::KIND_REBOOT : lbs_pkg::KIND_POWER;
                n_hold         = r_hold + COUNT_BITS'(1);
            end
            if (|s) begin
                n_hold = '0;
            end
            n_special = s;
            n_slider  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal  <= '0;
            r_special <= '0;
            r_sysrq   <= '0;
            r_slider  <= 1'b0;
            r_hold    <= '0;
        end else if (i_load) begin
            r_normal  <= n_normal;
            r_special <= n_special;
            r_sysrq   <= n_sysrq;
            r_slider  <= n_slider;
            r_hold    <= n_hold;
        end
    end

endmodule

`default_nettype wire

[rtl/lbs_ser.sv]
`default_nettype none

module lbs_ser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire lbs_pkg::t_job                i_job,
    input  wire logic                         i_out_ready,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [lbs_pkg::KIND_W-1:0]        o_kind,
    output logic [lbs_pkg::IDX_W-1:0]         o_idx,
    output logic                              o_pressed,
    output logic                              o_last
);

    logic [lbs_pkg::BTN_W-1:0]  r_sel, n_sel;
    logic [lbs_pkg::BTN_W-1:0]  r_lvl, n_lvl;
    logic [lbs_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [lbs_pkg::KIND_W-1:0] r_kind, n_kind;
    logic                       r_cnt_pend, n_cnt_pend;
    logic [lbs_pkg::KIND_W-1:0] r_cnt_kind, n_cnt_kind;
    logic                       r_busy, n_busy;
    logic                       r_ovalid, n_ovalid;
    logic [lbs_pkg::KIND_W-1:0] r_okind, n_okind;
    logic [lbs_pkg::IDX_W-1:0]  r_oidx, n_oidx;
    logic                       r_opressed, n_opressed;
    logic                       r_olast, n_olast;
    logic                       adv;

    assign adv = !r_ovalid || i_out_ready;

    always_comb begin
        n_sel      = r_sel;
        n_lvl      = r_lvl;
        n_idx      = r_idx;
        n_kind     = r_kind;
        n_cnt_pend = r_cnt_pend;
        n_cnt_kind = r_cnt_kind;
        n_busy     = r_busy;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_okind    = r_okind;
        n_oidx     = r_oidx;
        n_opressed = r_opressed;
        n_olast    = r_olast;
        if (i_load) begin
            n_sel      = i_job.sel;
            n_lvl      = i_job.lvl;
            n_idx      = '0;
            n_kind     = i_job.key_kind;
            n_cnt_pend = i_job.cnt_pend;
            n_cnt_kind = i_job.cnt_kind;
            n_busy     = 1'b1;
        end else if (r_busy && adv) begin
            if (|r_sel) begin
                // one button per cycle while the output is not stalled, lowest first
                if (r_sel[0]) begin
                    n_ovalid   = 1'b1;
                    n_okind    = r_kind;
                    n_oidx     = r_idx;
                    n_opressed = r_lvl[0];
                    n_olast    = !(|r_sel[lbs_pkg::BTN_W-1:1]) && !r_cnt_pend;
                end
                n_sel = r_sel >> 1;
                n_lvl = r_lvl >> 1;
                n_idx = r_idx + lbs_pkg::IDX_W'(1);
            end else begin
                if (r_cnt_pend) begin
                    n_ovalid   = 1'b1;
                    n_okind    = r_cnt_kind;
                    n_oidx     = '0;
                    n_opressed = 1'b1;
                    n_olast    = 1'b1;
                end
                n_cnt_pend = 1'b0;
                n_busy     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cnt_pend <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_ovalid   <= n_ovalid;
            r_cnt_pend <= n_cnt_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel      <= n_sel;
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_cnt_kind <= n_cnt_kind;
        r_okind    <= n_okind;
        r_oidx     <= n_oidx;
        r_opressed <= n_opressed;
        r_olast    <= n_olast;
    end

    assign o_busy    = r_busy;
    assign o_valid   = r_ovalid;
    assign o_kind    = r_okind;
    assign o_idx     = r_oidx;
    assign o_pressed = r_opressed;
    assign o_last    = r_olast;

endmodule

`default_nettype wire

[rtl/lbs_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module lbs_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lbs_pkg::KIND_W-1:0]  i_kind,
    input wire logic [lbs_pkg::IDX_W-1:0]   i_idx,
    input wire logic                        i_pressed,
    input wire logic                        i_last
);

    `LBS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_kind, i_idx, i_pressed, i_last}))
    `LBS_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, i_out_valid, i_kind <= lbs_pkg::KIND_REBOOT)
    `LBS_ASSERT_IMP(a_cnt_evt, i_clk, i_rst_n, i_out_valid && (i_kind == lbs_pkg::KIND_POWER || i_kind == lbs_pkg::KIND_REBOOT), i_idx == '0 && i_pressed && i_last)
    `LBS_ASSERT_IMP(a_sysrq_press, i_clk, i_rst_n, i_out_valid && i_kind == lbs_pkg::KIND_SYSRQ, i_pressed)
    `LBS_ASSERT_NXT(a_tick_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind layered_button_scanner_long_press_unit lbs_checker u_lbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_btn.valid),
    .i_in_ready  (i_btn.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_kind      (o_evt.event_kind),
    .i_idx       (o_evt.button_index),
    .i_pressed   (o_evt.pressed),
    .i_last      (o_evt.last)
);

`default_nettype wire

[verif/layered_button_scanner_long_press_unit_test.sv]
`timescale 1ns / 100ps

module layered_button_scanner_long_press_unit_test;

    localparam logic [lbs_pkg::TICK_W-1:0] HOLD_MAX = '1;

    typedef struct packed {
        logic [lbs_pkg::BTN_W-1:0] raw;
        logic                      slider;
    } t_scan;

    typedef struct packed {
        logic [lbs_pkg::KIND_W-1:0] kind;
        logic [lbs_pkg::IDX_W-1:0]  idx;
        logic                       pressed;
        logic                       last;
    } t_evt;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we;
    logic [lbs_pkg::CFG_ADDR_W-1:0] i_cfg_idx;
    logic [lbs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lbs_in_if  btn_if();
    lbs_out_if evt_if();

    layered_button_scanner_long_press_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_btn      (btn_if),
        .o_evt      (evt_if)
    );

    // Scanner state as the checker sees it
    lbs_pkg::t_cfg              cfg;
    logic [lbs_pkg::BTN_W-1:0]  normal_last  = '0;
    logic [lbs_pkg::BTN_W-1:0]  special_last = '0;
    logic [lbs_pkg::BTN_W-1:0]  sysrq_last   = '0;
    logic                       slider_last  = 1'b0;
    logic [lbs_pkg::TICK_W-1:0] hold_count   = '0;

    t_scan pending_scans[$];
    t_evt  expected_events[$];
    int    fails = 0;

    logic        calm_send = 1'b0;
    logic        calm_recv = 1'b0;
    logic        stall_arm = 1'b0;
    int unsigned stall_left;
    int unsigned send_gap;
    int unsigned recv_gap;

    logic [lbs_pkg::BTN_W-1:0] gen_lvl = '0;
    logic                      gen_slider = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void predict_scan(logic [lbs_pkg::BTN_W-1:0] raw, logic slider);
        logic [lbs_pkg::BTN_W-1:0]  lvl;
        logic [lbs_pkg::BTN_W-1:0]  sel;
        logic                       combo;
        logic [lbs_pkg::KIND_W-1:0] kind;
        t_evt                       found[$];
        t_evt                       ev;
        int                         i;
        lvl = raw ^ cfg.active_low_mask;
        combo = 1'b0;
        if (cfg.combo_en && cfg.combo_idx < lbs_pkg::BTN_W) begin
            combo = lvl[cfg.combo_idx];
        end
        if (!slider) begin
            sel = (lvl ^ normal_last) & cfg.normal_code_mask;
            kind = lbs_pkg::KIND_NORMAL;
            hold_count = '0;
            normal_last = lvl;
            slider_last = 1'b0;
        end else if (combo) begin
            sel = (lvl ^ sysrq_last) & lvl & cfg.sysrq_code_mask;
            kind = lbs_pkg::KIND_SYSRQ;
            hold_count = '0;
            sysrq_last = lvl;
        end else begin
            sel = (lvl ^ special_last) & cfg.special_code_mask;
            kind = lbs_pkg::KIND_SPECIAL;
        end
        for (i = 0; i < lbs_pkg::BTN_W; i++) begin
            if (sel[i]) begin
                found.push_back('{kind, lbs_pkg::IDX_W'(i), lvl[i], 1'b0});
            end
        end
        if (slider && !combo) begin
            if (!slider_last) begin
                hold_count = 1;
            end else if (hold_count != 0 && hold_count != HOLD_MAX) begin
                // reboot wins when both counts match
                if (hold_count == cfg.reboot_ticks) begin
                    found.push_back('{lbs_pkg::KIND_REBOOT, lbs_pkg::IDX_W'(0), 1'b1, 1'b0});
                end else if (hold_count == cfg.power_ticks) begin
                    found.push_back('{lbs_pkg::KIND_POWER, lbs_pkg::IDX_W'(0), 1'b1, 1'b0});
                end
                hold_count = hold_count + 1'b1;
            end
            if (lvl != 0) begin
                hold_count = '0;
            end
            special_last = lvl;
            slider_last = 1'b1;
        end
        for (i = 0; i < found.size(); i++) begin
            ev = found[i];
            ev.last = (i == found.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // Driver: scan ticks
    always @(posedge i_clk) begin : scan_driver
        t_scan nxt;
        if (!i_rst_n) begin
            btn_if.valid <= 1'b0;
            send_gap <= 0;
        end else if (!btn_if.valid || btn_if.ready) begin
            if (send_gap != 0) begin
                btn_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_scans.size() != 0) begin
                nxt = pending_scans.pop_front();
                btn_if.buttons_raw <= nxt.raw;
                btn_if.slider_held <= nxt.slider;
                btn_if.valid <= 1'b1;
                send_gap <= calm_send ? 0 : $urandom_range(0, 5);
            end else begin
                btn_if.valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the event side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_arm) begin
            stall_left <= 300;
        end
    end

    // Event sink
    always @(posedge i_clk) begin : event_sink
        int unsigned w;
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
            recv_gap <= 0;
        end else if (stall_left != 0) begin
            evt_if.ready <= 1'b0;
        end else if (evt_if.ready) begin
            if (evt_if.valid) begin
                w = calm_recv ? 0 : $urandom_range(0, 5);
                recv_gap <= w;
                evt_if.ready <= (w == 0);
            end
        end else if (recv_gap <= 1) begin
            evt_if.ready <= 1'b1;
            recv_gap <= 0;
        end else begin
            recv_gap <= recv_gap - 1;
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin : event_monitor
        t_evt want;
        if (i_rst_n) begin
            if (btn_if.valid && btn_if.ready) begin
                predict_scan(btn_if.buttons_raw, btn_if.slider_held);
            end
            if (evt_if.valid && evt_if.ready) begin
                if (expected_events.size() == 0) begin
                    fails++;
                    $display("%0t: expected no beat, got kind %0d button %0d pressed %0b last %0b",
                             $time, evt_if.event_kind, evt_if.button_index, evt_if.pressed,
                             evt_if.last);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 4'(want.kind), 4'(evt_if.event_kind));
                    check_field("button_index", want.idx, evt_if.button_index);
                    check_field("pressed", 4'(want.pressed), 4'(evt_if.pressed));
                    check_field("last", 4'(want.last), 4'(evt_if.last));
                end
            end
        end
    end

    task automatic add_scan(logic [lbs_pkg::BTN_W-1:0] lvl, logic slider);
        pending_scans.push_back('{lvl ^ cfg.active_low_mask, slider});
    endtask

    task automatic cfg_write(logic [lbs_pkg::CFG_ADDR_W-1:0] idx,
                             logic [lbs_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            lbs_pkg::REG_ACTIVE_LOW:   cfg.active_low_mask = val[lbs_pkg::BTN_W-1:0];
            lbs_pkg::REG_NORMAL_MASK:  cfg.normal_code_mask = val[lbs_pkg::BTN_W-1:0];
            lbs_pkg::REG_SPECIAL_MASK: cfg.special_code_mask = val[lbs_pkg::BTN_W-1:0];
            lbs_pkg::REG_SYSRQ_MASK:   cfg.sysrq_code_mask = val[lbs_pkg::BTN_W-1:0];
            lbs_pkg::REG_COMBO_IDX:    cfg.combo_idx = val[lbs_pkg::IDX_W-1:0];
            lbs_pkg::REG_COMBO_EN:     cfg.combo_en = val[0];
            lbs_pkg::REG_POWER_TICKS:  cfg.power_ticks = val[lbs_pkg::TICK_W-1:0];
            lbs_pkg::REG_REBOOT_TICKS: cfg.reboot_ticks = val[lbs_pkg::TICK_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A scan with no events may still be in the serializer: pad past its latency
    task automatic wait_idle();
        while (pending_scans.size() != 0 || btn_if.valid || expected_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [lbs_pkg::CFG_DATA_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic logic [lbs_pkg::CFG_DATA_W-1:0] pick_ticks();
        if ($urandom_range(0, 9) == 0) begin
            return 16'hFFFF;
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic random_setup();
        cfg_write(lbs_pkg::REG_ACTIVE_LOW, pick_mask());
        cfg_write(lbs_pkg::REG_NORMAL_MASK, pick_mask());
        cfg_write(lbs_pkg::REG_SPECIAL_MASK, pick_mask());
        cfg_write(lbs_pkg::REG_SYSRQ_MASK, pick_mask());
        cfg_write(lbs_pkg::REG_COMBO_IDX, ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                                       : $urandom_range(0, 11));
        cfg_write(lbs_pkg::REG_COMBO_EN, ($urandom_range(0, 3) != 0));
        cfg_write(lbs_pkg::REG_POWER_TICKS, pick_ticks());
        cfg_write(lbs_pkg::REG_REBOOT_TICKS, pick_ticks());
    endtask

    task automatic random_scans(int count);
        int made;
        int run;
        int k;
        int j;
        made = 0;
        while (made < count) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                gen_lvl = $urandom_range(0, 4095);
                gen_slider = $urandom_range(0, 1);
                add_scan(gen_lvl, gen_slider);
                made++;
            end else if (k < 20) begin
                // release, then hold the slider with idle buttons
                run = (cfg.reboot_ticks > cfg.power_ticks) ? cfg.reboot_ticks : cfg.power_ticks;
                run = (run > 22) ? 24 : run + 2;
                gen_lvl = '0;
                add_scan('0, 1'b0);
                for (j = 0; j < run; j++) begin
                    add_scan('0, 1'b1);
                end
                gen_slider = 1'b1;
                made += run + 1;
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    j = $urandom_range(0, lbs_pkg::BTN_W - 1);
                    gen_lvl[j] = ~gen_lvl[j];
                end
                if ($urandom_range(0, 6) == 0) begin
                    gen_slider = ~gen_slider;
                end
                if (gen_slider && cfg.combo_idx < lbs_pkg::BTN_W &&
                    $urandom_range(0, 3) == 0) begin
                    gen_lvl[cfg.combo_idx] = 1'b1;
                end
                add_scan(gen_lvl, gen_slider);
                made++;
            end
        end
    endtask

    initial begin : timeout
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int k;
        btn_if.valid = 1'b0;
        btn_if.buttons_raw = '0;
        btn_if.slider_held = 1'b0;
        evt_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cfg = {lbs_pkg::RST_ACTIVE_LOW, lbs_pkg::RST_NORMAL_MASK, lbs_pkg::RST_SPECIAL_MASK,
               lbs_pkg::RST_SYSRQ_MASK, lbs_pkg::RST_COMBO_IDX, lbs_pkg::RST_COMBO_EN,
               lbs_pkg::RST_POWER_TICKS, lbs_pkg::RST_REBOOT_TICKS};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: every layer
        add_scan(12'h000, 1'b0);
        add_scan(12'hFFF, 1'b0);
        add_scan(12'h000, 1'b0);
        add_scan(12'h000, 1'b1);
        add_scan(12'h001, 1'b1);
        add_scan(12'hC0F, 1'b1);
        add_scan(12'hC0F, 1'b1);
        add_scan(12'h001, 1'b1);
        add_scan(12'h000, 1'b0);
        add_scan(12'hFFF, 1'b1);
        wait_idle();

        // Short hold: power click then reboot
        cfg_write(lbs_pkg::REG_ACTIVE_LOW, 12'h000);
        cfg_write(lbs_pkg::REG_NORMAL_MASK, 12'hFFF);
        cfg_write(lbs_pkg::REG_SPECIAL_MASK, 12'hFFF);
        cfg_write(lbs_pkg::REG_SYSRQ_MASK, 12'hFFF);
        cfg_write(lbs_pkg::REG_COMBO_IDX, 0);
        cfg_write(lbs_pkg::REG_COMBO_EN, 1);
        cfg_write(lbs_pkg::REG_POWER_TICKS, 3);
        cfg_write(lbs_pkg::REG_REBOOT_TICKS, 6);
        add_scan(12'h000, 1'b0);
        repeat (8) add_scan(12'h000, 1'b1);
        wait_idle();

        // Both counts equal; combo index out of range
        cfg_write(lbs_pkg::REG_POWER_TICKS, 1);
        cfg_write(lbs_pkg::REG_REBOOT_TICKS, 1);
        cfg_write(lbs_pkg::REG_COMBO_IDX, 15);
        add_scan(12'h000, 1'b0);
        add_scan(12'h000, 1'b1);
        add_scan(12'h000, 1'b1);
        add_scan(12'hFFF, 1'b1);
        wait_idle();

        // Zero power count, combo disabled, empty normal mask
        cfg_write(lbs_pkg::REG_ACTIVE_LOW, 12'hA5A);
        cfg_write(lbs_pkg::REG_NORMAL_MASK, 12'h000);
        cfg_write(lbs_pkg::REG_POWER_TICKS, 0);
        cfg_write(lbs_pkg::REG_REBOOT_TICKS, 2);
        cfg_write(lbs_pkg::REG_COMBO_IDX, 3);
        cfg_write(lbs_pkg::REG_COMBO_EN, 0);
        add_scan(12'h000, 1'b0);
        repeat (3) add_scan(12'h000, 1'b1);
        add_scan(12'h008, 1'b1);
        add_scan(12'hFFF, 1'b0);
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            @(posedge i_clk);
            calm_send <= (ph == 1);
            calm_recv <= (ph == 2);
            random_setup();
            random_scans(60);
            wait_idle();
        end

        // Hold off the sink while every scan after the first yields a full set of beats
        @(posedge i_clk);
        calm_send <= 1'b1;
        calm_recv <= 1'b0;
        cfg_write(lbs_pkg::REG_NORMAL_MASK, 12'hFFF);
        @(posedge i_clk);
        stall_arm <= 1'b1;
        @(posedge i_clk);
        stall_arm <= 1'b0;
        for (k = 0; k < 30; k++) begin
            add_scan((k % 2) ? 12'h000 : 12'hFFF, 1'b0);
        end

        k = 0;
        while (k < 20000 && (pending_scans.size() != 0 || btn_if.valid ||
                             expected_events.size() != 0)) begin
            @(negedge i_clk);
            if (pending_scans.size() == 0 && !btn_if.valid) begin
                k++;
            end
        end
        repeat (30) @(negedge i_clk);
        if (expected_events.size() != 0) begin
            fails++;
            $display("%0t: %0d expected beats never arrived", $time, expected_events.size());
        end
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
